[rtl/plot_point_affine_transform_assert.svh]
// Assertion macros for the plot point affine transform checker
`ifndef PLOT_POINT_AFFINE_TRANSFORM_ASSERT_SVH
`define PLOT_POINT_AFFINE_TRANSFORM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define PPAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset
`define PPAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/ppat_pkg.sv]
// Package: types, constants and helpers for the plot point affine transform
package ppat_pkg;
	localparam int COORD_BITS = 16;
	localparam int ADDR_BITS = 6;
	// largest and smallest result coordinate
	localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] COORD_MIN = -COORD_MAX - 64'sd1;
	// square root steps: one per even bit of a 35-bit sum of squares
	localparam int ROOT_STEPS = 18;

	localparam logic [1:0] OP_POINT2D = 2'd0;
	localparam logic [1:0] OP_POINT3D = 2'd1;
	localparam logic [1:0] OP_SPACE2D = 2'd2;
	localparam logic [1:0] OP_SPACE3D = 2'd3;

	localparam logic [2:0] REG_ROT_X = 3'd0;
	localparam logic [2:0] REG_ROT_Y = 3'd1;
	localparam logic [2:0] REG_ROT_Z = 3'd2;
	localparam logic [2:0] REG_TRANS = 3'd3;
	localparam logic [2:0] REG_SCALE = 3'd4;
	localparam logic [2:0] REG_MODE = 3'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] first_z;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic signed [15:0] second_z;
	} req_t;

	typedef struct packed {
		logic is_box;
		logic signed [15:0] res_ax;
		logic signed [15:0] res_ay;
		logic signed [15:0] res_az;
		logic signed [15:0] res_bx;
		logic signed [15:0] res_by;
		logic signed [15:0] res_bz;
		logic clipped;
	} res_t;

	typedef struct packed {
		logic [53:0] rot_x;
		logic [53:0] rot_y;
		logic [53:0] rot_z;
		logic [62:0] trans;
		logic signed [31:0] scale;
		logic [1:0] mode;
	} cfg_t;

	// datapath operations requested by the controller
	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_PASS, DP_ARM, DP_CENTER, DP_PROD, DP_ROW_DONE, DP_SUMSQ,
		DP_SQRT_STEP, DP_BOX_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [1:0] j;
		logic [1:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic is_box;
		logic model;
	} dp_sts_t;
endpackage

[rtl/ppat_ctrl.sv]
// Controller: sequences datapath operations for one request at a time
module ppat_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input ppat_pkg::dp_sts_t sts,
	output ppat_pkg::dp_cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_CENTER, S_ROW, S_SUMSQ, S_ROOT, S_FINISH, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] j_q;
	logic [1:0] k_q;
	logic [4:0] cnt_q;
	logic out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// issue the command for the current step
	always_comb begin
		cmd.op = ppat_pkg::DP_NOP;
		cmd.j = j_q;
		cmd.k = k_q;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = ppat_pkg::DP_LOAD;
			S_DECODE: begin
				if (sts.is_box) cmd.op = sts.model ? ppat_pkg::DP_ARM : ppat_pkg::DP_PASS;
			end
			S_CENTER: cmd.op = ppat_pkg::DP_CENTER;
			S_ROW: cmd.op = (k_q == 2'd3) ? ppat_pkg::DP_ROW_DONE : ppat_pkg::DP_PROD;
			S_SUMSQ: cmd.op = ppat_pkg::DP_SUMSQ;
			S_ROOT: cmd.op = ppat_pkg::DP_SQRT_STEP;
			S_FINISH: cmd.op = ppat_pkg::DP_BOX_DONE;
			S_OUT: cmd.op = ppat_pkg::DP_NOP;
		endcase
	end

	// advance state and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DECODE;
					j_q <= '0;
					k_q <= '0;
					cnt_q <= '0;
				end
				S_DECODE: begin
					if (sts.is_box && !sts.model) begin
						state_q <= S_OUT;
						out_valid_q <= 1'b1;
					end else if (sts.is_box) state_q <= S_SUMSQ;
					else state_q <= S_CENTER;
				end
				S_CENTER: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_ROW;
					end else k_q <= k_q + 2'd1;
				end
				S_ROW: begin
					if (k_q == 2'd3) begin
						k_q <= '0;
						if (j_q == 2'd2) begin
							state_q <= S_OUT;
							out_valid_q <= 1'b1;
						end else j_q <= j_q + 2'd1;
					end else k_q <= k_q + 2'd1;
				end
				S_SUMSQ: begin
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_ROOT;
					end else k_q <= k_q + 2'd1;
				end
				S_ROOT: begin
					if (cnt_q == 5'(ppat_pkg::ROOT_STEPS - 1)) state_q <= S_FINISH;
					else cnt_q <= cnt_q + 5'd1;
				end
				S_FINISH: begin
					state_q <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/ppat_dp.sv]
// Datapath: shared multiplier, accumulator, square root and box state
module ppat_dp (
	input logic clk,
	input logic arst_n,
	input ppat_pkg::req_t req,
	input ppat_pkg::cfg_t cfg,
	input ppat_pkg::dp_cmd_t cmd,
	output ppat_pkg::dp_sts_t sts,
	output ppat_pkg::res_t res
);
	localparam logic signed [63:0] HI = ppat_pkg::COORD_MAX;
	localparam logic signed [63:0] LO = ppat_pkg::COORD_MIN;
	localparam logic [35:0] ROOT_TOP = 36'd1 << 34;

	ppat_pkg::req_t req_q;
	logic signed [17:0] centre_q [3];
	logic armed_q;
	logic signed [44:0] q_q [3];
	logic signed [63:0] acc_q;
	logic [35:0] rem_q;
	logic [35:0] root_q;
	logic [35:0] bit_q;
	ppat_pkg::res_t res_q;

	logic signed [15:0] a [3];
	logic signed [15:0] b [3];
	logic [1:0] kk;
	logic scaling;
	logic [53:0] rot;
	logic signed [17:0] coef;
	logic signed [62:0] cprod;
	logic signed [20:0] tr_sel;
	logic signed [63:0] tr;
	logic signed [17:0] diff;
	logic signed [49:0] sc;
	logic signed [49:0] sc_mag;
	logic signed [49:0] sc_q;
	logic signed [44:0] q_next;
	logic signed [16:0] d;
	logic signed [33:0] sq;
	logic signed [63:0] mag;
	logic signed [63:0] rv;
	logic [15:0] rsat;
	logic rclip;
	logic [35:0] rb;
	logic [18:0] half;
	logic hclip;
	logic [15:0] vsat;

	assign kk = (cmd.k == 2'd3) ? 2'd0 : cmd.k;
	assign scaling = cfg.mode[0] | armed_q;

	// operand selection
	always_comb begin
		a[0] = req_q.first_x;
		a[1] = req_q.first_y;
		a[2] = req_q.first_z;
		b[0] = req_q.second_x;
		b[1] = req_q.second_y;
		b[2] = req_q.second_z;
		if (req_q.opcode == ppat_pkg::OP_POINT2D || req_q.opcode == ppat_pkg::OP_SPACE2D) begin
			a[2] = -16'sd1;
			b[2] = 16'sd1;
		end
		if (req_q.opcode == ppat_pkg::OP_POINT2D) a[2] = 16'sd0;
	end

	assign sts.is_box = req_q.opcode[1];
	assign sts.model = cfg.mode[1];

	// shared multiplier paths
	always_comb begin
		unique case (cmd.j)
			2'd0: begin
				rot = cfg.rot_x;
				tr_sel = cfg.trans[20:0];
			end
			2'd1: begin
				rot = cfg.rot_y;
				tr_sel = cfg.trans[41:21];
			end
			default: begin
				rot = cfg.rot_z;
				tr_sel = cfg.trans[62:42];
			end
		endcase
		coef = rot[18*kk +: 18];
		cprod = coef * q_q[kk];
		tr = {{17{tr_sel[20]}}, tr_sel, 26'd0};
		// centre and scale, truncated toward zero to Q.12
		diff = {a[kk][15], a[kk], 1'b0} - centre_q[kk];
		sc = diff * cfg.scale;
		sc_mag = sc[49] ? -sc : sc;
		sc_q = sc[49] ? -(sc_mag >>> 5) : (sc_mag >>> 5);
		q_next = scaling ? sc_q[44:0] : {{17{a[kk][15]}}, a[kk], 12'd0};
		// truncate the row sum toward zero and saturate
		mag = acc_q[63] ? -acc_q : acc_q;
		rv = acc_q[63] ? -(mag >>> 26) : (mag >>> 26);
		rclip = (rv > HI) || (rv < LO);
		rsat = (rv > HI) ? HI[15:0] : (rv < LO) ? LO[15:0] : rv[15:0];
		// box extent and square root
		d = {b[kk][15], b[kk]} - {a[kk][15], a[kk]};
		sq = d * d;
		rb = root_q + bit_q;
		half = ({1'b0, root_q[17:0]} + 19'd1) >> 1;
		hclip = $signed({45'd0, half}) > HI;
		vsat = hclip ? HI[15:0] : half[15:0];
	end

	assign res = res_q;

	// run the commanded step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			for (int i = 0; i < 3; i++) begin
				centre_q[i] <= '0;
				q_q[i] <= '0;
			end
			armed_q <= 1'b0;
			acc_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			bit_q <= '0;
			res_q <= '0;
		end else begin
			unique case (cmd.op)
				ppat_pkg::DP_LOAD: req_q <= req;
				ppat_pkg::DP_PASS: begin
					res_q.is_box <= 1'b1;
					res_q.clipped <= 1'b0;
					res_q.res_ax <= a[0];
					res_q.res_ay <= a[1];
					res_q.res_az <= a[2];
					res_q.res_bx <= b[0];
					res_q.res_by <= b[1];
					res_q.res_bz <= b[2];
				end
				ppat_pkg::DP_ARM: begin
					for (int i = 0; i < 3; i++)
						centre_q[i] <= {{2{b[i][15]}}, b[i]} + {{2{a[i][15]}}, a[i]};
					armed_q <= 1'b1;
					rem_q <= '0;
					root_q <= '0;
					bit_q <= ROOT_TOP;
				end
				ppat_pkg::DP_CENTER: q_q[kk] <= q_next;
				ppat_pkg::DP_PROD: begin
					acc_q <= ((cmd.k == 2'd0) ? tr : acc_q) + $signed({cprod[62], cprod});
				end
				ppat_pkg::DP_ROW_DONE: begin
					res_q.is_box <= 1'b0;
					res_q.res_bx <= '0;
					res_q.res_by <= '0;
					res_q.res_bz <= '0;
					res_q.clipped <= (cmd.j == 2'd0) ? rclip : (res_q.clipped | rclip);
					unique case (cmd.j)
						2'd0: res_q.res_ax <= rsat;
						2'd1: res_q.res_ay <= rsat;
						default: res_q.res_az <= rsat;
					endcase
				end
				ppat_pkg::DP_SUMSQ: rem_q <= rem_q + {2'b00, sq};
				ppat_pkg::DP_SQRT_STEP: begin
					if (rem_q >= rb) begin
						rem_q <= rem_q - rb;
						root_q <= (root_q >> 1) + bit_q;
					end else root_q <= root_q >> 1;
					bit_q <= bit_q >> 2;
				end
				ppat_pkg::DP_BOX_DONE: begin
					res_q.is_box <= 1'b1;
					res_q.clipped <= hclip;
					res_q.res_ax <= -$signed(vsat);
					res_q.res_ay <= -$signed(vsat);
					res_q.res_az <= -$signed(vsat);
					res_q.res_bx <= vsat;
					res_q.res_by <= vsat;
					res_q.res_bz <= vsat;
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/plot_point_affine_transform.sv]
// A point request is decoded, centred in three steps and then computed as three rows
// of four steps; a model box is decoded, sums three squares, runs an 18-step square
// root and finishes; a pass-through box is decoded and output directly.
// One request at a time: the next is taken in the cycle after the result leaves.
// Reset (arst_n low) restores identity rotation, unit scale and clears the centre.
module plot_point_affine_transform (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ppat_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ppat_pkg::res_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ppat_pkg::ADDR_BITS-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	ppat_pkg::cfg_t cfg_q;
	ppat_pkg::dp_cmd_t cmd;
	ppat_pkg::dp_sts_t sts;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx = paddr[5:3];

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_x <= 54'd16384;
			cfg_q.rot_y <= 54'd16384 << 18;
			cfg_q.rot_z <= 54'd16384 << 36;
			cfg_q.trans <= '0;
			cfg_q.scale <= 32'sd65536;
			cfg_q.mode <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				ppat_pkg::REG_ROT_X: cfg_q.rot_x <= pwdata[53:0];
				ppat_pkg::REG_ROT_Y: cfg_q.rot_y <= pwdata[53:0];
				ppat_pkg::REG_ROT_Z: cfg_q.rot_z <= pwdata[53:0];
				ppat_pkg::REG_TRANS: cfg_q.trans <= pwdata[62:0];
				ppat_pkg::REG_SCALE: cfg_q.scale <= pwdata[31:0];
				ppat_pkg::REG_MODE: cfg_q.mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (idx)
			ppat_pkg::REG_ROT_X: prdata = 64'(cfg_q.rot_x);
			ppat_pkg::REG_ROT_Y: prdata = 64'(cfg_q.rot_y);
			ppat_pkg::REG_ROT_Z: prdata = 64'(cfg_q.rot_z);
			ppat_pkg::REG_TRANS: prdata = 64'(cfg_q.trans);
			ppat_pkg::REG_SCALE: prdata = 64'(unsigned'(cfg_q.scale));
			ppat_pkg::REG_MODE: prdata = 64'(cfg_q.mode);
			default: prdata = '0;
		endcase
	end

	ppat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	ppat_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cfg(cfg_q), .cmd(cmd),
		.sts(sts), .res(out_data)
	);
endmodule

[rtl/ppat_checker.sv]
// Port checker for the plot point affine transform, bound to the top level
`include "plot_point_affine_transform_assert.svh"
module ppat_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ppat_pkg::res_t out_data,
	input logic pready
);
	`PPAT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`PPAT_ASSERT_IMPL(a_one_at_a_time, clk, arst_n, out_valid, in_stall)
	`PPAT_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`PPAT_ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind plot_point_affine_transform ppat_checker u_ppat_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .pready(pready)
);

[dv/plot_point_affine_transform_test.sv]
// Self-checking testbench for the plot point affine transform block
module plot_point_affine_transform_test;
	typedef struct {
		ppat_pkg::req_t req;
		bit typed;
		ppat_pkg::res_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ppat_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ppat_pkg::res_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ppat_pkg::ADDR_BITS-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	// shadow of the register file and of the centre state
	bit [53:0] rot_row [3];
	bit [62:0] shift_xyz;
	logic signed [31:0] scale_q16;
	bit [1:0] mode;
	longint twice_centre [3];
	bit armed;

	ppat_pkg::res_t pending_results [$];
	row_t directed [$];
	int send_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	plot_point_affine_transform dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic logic signed [127:0] trunc_zero(logic signed [127:0] v, int sh);
		if (v < 0)
			return -((-v) >>> sh);
		return v >>> sh;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// compute the result of one request and advance the centre state
	function automatic ppat_pkg::res_t transform_item(ppat_pkg::req_t r);
		ppat_pkg::res_t o;
		longint a [3];
		longint b [3];
		longint c [6];
		logic signed [127:0] q [3];
		logic signed [127:0] acc;
		logic signed [127:0] t;
		logic signed [127:0] sc;
		logic signed [17:0] coef;
		logic signed [20:0] tr;
		longint unsigned s;
		longint unsigned v;
		bit clip;
		clip = 0;
		a[0] = longint'(r.first_x); a[1] = longint'(r.first_y); a[2] = longint'(r.first_z);
		b[0] = longint'(r.second_x); b[1] = longint'(r.second_y);
		b[2] = longint'(r.second_z);
		if (r.opcode == ppat_pkg::OP_POINT2D || r.opcode == ppat_pkg::OP_SPACE2D) begin
			a[2] = -1;
			b[2] = 1;
		end
		if (r.opcode == ppat_pkg::OP_POINT2D || r.opcode == ppat_pkg::OP_POINT3D) begin
			if (r.opcode == ppat_pkg::OP_POINT2D) a[2] = 0;
			sc = 128'(scale_q16);
			for (int k = 0; k < 3; k++) begin
				if (mode[0] || armed) begin
					t = 128'(2 * a[k] - twice_centre[k]);
					q[k] = trunc_zero(t * sc, 5);
				end else
					q[k] = 128'(a[k] * 4096);
			end
			for (int j = 0; j < 3; j++) begin
				tr = shift_xyz[21*j +: 21];
				acc = 128'(tr);
				acc = acc <<< 26;
				for (int k = 0; k < 3; k++) begin
					coef = rot_row[j][18*k +: 18];
					t = 128'(coef);
					acc += t * q[k];
				end
				acc = trunc_zero(acc, 26);
				if (acc > 32767) begin acc = 32767; clip = 1; end
				if (acc < -32768) begin acc = -32768; clip = 1; end
				c[j] = longint'(acc);
				c[3+j] = 0;
			end
		end else if (mode[1]) begin
			s = 0;
			for (int k = 0; k < 3; k++) begin
				twice_centre[k] = b[k] + a[k];
				s += longint'(unsigned'((b[k] - a[k]) * (b[k] - a[k])));
			end
			armed = 1;
			v = (int_sqrt(s) + 1) >> 1;
			if (v > 32767) begin v = 32767; clip = 1; end
			for (int k = 0; k < 3; k++) begin
				c[k] = -longint'(v);
				c[3+k] = longint'(v);
			end
		end else
			for (int k = 0; k < 3; k++) begin
				c[k] = a[k];
				c[3+k] = b[k];
			end
		o.is_box = r.opcode[1];
		o.res_ax = 16'(c[0]); o.res_ay = 16'(c[1]); o.res_az = 16'(c[2]);
		o.res_bx = 16'(c[3]); o.res_by = 16'(c[4]); o.res_bz = 16'(c[5]);
		o.clipped = clip;
		return o;
	endfunction

	function automatic ppat_pkg::req_t mk(logic [1:0] op, int x, int y, int z, int x2, int y2,
			int z2);
		ppat_pkg::req_t r;
		r.opcode = op;
		r.first_x = 16'(x); r.first_y = 16'(y); r.first_z = 16'(z);
		r.second_x = 16'(x2); r.second_y = 16'(y2); r.second_z = 16'(z2);
		return r;
	endfunction

	function automatic ppat_pkg::res_t mkres(bit bx, int ax, int ay, int az, int bx2, int by,
			int bz, bit clip);
		ppat_pkg::res_t o;
		o.is_box = bx;
		o.res_ax = 16'(ax); o.res_ay = 16'(ay); o.res_az = 16'(az);
		o.res_bx = 16'(bx2); o.res_by = 16'(by); o.res_bz = 16'(bz);
		o.clipped = clip;
		return o;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
			3: return 16'($urandom_range(200) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [53:0] rand_row(int j, int style);
		logic [17:0] cf [3];
		for (int k = 0; k < 3; k++)
			case (style)
				0: cf[k] = (j == k) ? 18'd16384 : 18'd0;
				1: cf[k] = 18'($urandom_range(32768) - 16384);
				2: cf[k] = $urandom_range(1) ? 18'h1FFFF : 18'h20000;
				default: cf[k] = 18'($urandom);
			endcase
		return {cf[2], cf[1], cf[0]};
	endfunction

	// drive one register write through setup and access cycles
	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 3'b000}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			ppat_pkg::REG_ROT_X: rot_row[0] = v[53:0];
			ppat_pkg::REG_ROT_Y: rot_row[1] = v[53:0];
			ppat_pkg::REG_ROT_Z: rot_row[2] = v[53:0];
			ppat_pkg::REG_TRANS: shift_xyz = v[62:0];
			ppat_pkg::REG_SCALE: scale_q16 = v[31:0];
			ppat_pkg::REG_MODE: mode = v[1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// hold valid, wait for the request to be taken and record its result
	task automatic send(ppat_pkg::req_t r, bit typed, ppat_pkg::res_t want);
		ppat_pkg::res_t p;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		p = transform_item(r);
		pending_results.push_back(typed ? want : p);
		@(negedge clk);
	endtask

	// drop valid and let the block drain before touching registers
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_all(int style, logic [62:0] tr, logic [31:0] sc, logic [1:0] m);
		reg_write(ppat_pkg::REG_ROT_X, 64'(rand_row(0, style)));
		reg_write(ppat_pkg::REG_ROT_Y, 64'(rand_row(1, style)));
		reg_write(ppat_pkg::REG_ROT_Z, 64'(rand_row(2, style)));
		reg_write(ppat_pkg::REG_TRANS, 64'(tr));
		reg_write(ppat_pkg::REG_SCALE, 64'(sc));
		reg_write(ppat_pkg::REG_MODE, 64'(m));
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %0d got %0d", name, want, got);
		end
	endtask

	// randomized receiver stall
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// compare each taken result against the oldest expectation
	always @(posedge clk) begin
		ppat_pkg::res_t w;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				w = pending_results.pop_front();
				check_field("is_box", out_data.is_box, w.is_box);
				check_field("res_ax", out_data.res_ax, w.res_ax);
				check_field("res_ay", out_data.res_ay, w.res_ay);
				check_field("res_az", out_data.res_az, w.res_az);
				check_field("res_bx", out_data.res_bx, w.res_bx);
				check_field("res_by", out_data.res_by, w.res_by);
				check_field("res_bz", out_data.res_bz, w.res_bz);
				check_field("clipped", out_data.clipped, w.clipped);
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("[plot_point_affine_transform] ERROR");
			$finish;
		end
	end

	initial begin
		ppat_pkg::res_t none;
		ppat_pkg::req_t r;
		int op;
		none = '0;
		rot_row[0] = 54'd16384;
		rot_row[1] = 54'd16384 << 18;
		rot_row[2] = 54'd16384 << 36;
		shift_xyz = '0;
		scale_q16 = 32'sd65536;
		mode = 2'd0;
		twice_centre = '{0, 0, 0};
		armed = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state: identity, no scaling, boxes pass through
		directed.push_back('{mk(ppat_pkg::OP_POINT3D, 100, -200, 300, 7, 7, 7), 1,
			mkres(0, 100, -200, 300, 0, 0, 0, 0)});
		directed.push_back('{mk(ppat_pkg::OP_POINT2D, 5, 6, 999, -1, -1, -1), 1,
			mkres(0, 5, 6, 0, 0, 0, 0, 0)});
		directed.push_back('{mk(ppat_pkg::OP_POINT3D, -32768, 32767, -32768, 0, 0, 0), 1,
			mkres(0, -32768, 32767, -32768, 0, 0, 0, 0)});
		directed.push_back('{mk(ppat_pkg::OP_SPACE3D, -32768, -5, 9, 32767, 4, -9), 1,
			mkres(1, -32768, -5, 9, 32767, 4, -9, 0)});
		directed.push_back('{mk(ppat_pkg::OP_SPACE2D, 3, 4, 500, 8, 9, 600), 1,
			mkres(1, 3, 4, -1, 8, 9, 1, 0)});
		foreach (directed[i])
			send(directed[i].req, directed[i].typed, directed[i].want);
		drain();

		// model mode: centring boxes with points after them, oversized cube, inverted and 2D boxes
		reg_write(ppat_pkg::REG_MODE, 64'd2);
		directed.delete();
		directed.push_back('{mk(ppat_pkg::OP_SPACE3D, -10, -10, -10, 10, 10, 10), 1,
			mkres(1, -17, -17, -17, 17, 17, 17, 0)});
		directed.push_back('{mk(ppat_pkg::OP_POINT3D, 5, -5, 10, 0, 0, 0), 0, none});
		directed.push_back('{mk(ppat_pkg::OP_SPACE3D, -32768, -32768, -32768,
			32767, 32767, 32767), 1,
			mkres(1, -32767, -32767, -32767, 32767, 32767, 32767, 1)});
		directed.push_back('{mk(ppat_pkg::OP_POINT3D, 32767, -32768, 32767, 0, 0, 0), 0,
			none});
		directed.push_back('{mk(ppat_pkg::OP_SPACE3D, 50, 60, 70, -50, 10, 20), 0, none});
		directed.push_back('{mk(ppat_pkg::OP_POINT2D, 40, -40, 1234, 0, 0, 0), 0, none});
		directed.push_back('{mk(ppat_pkg::OP_SPACE2D, 100, 200, 300, 140, 230, -300), 0,
			none});
		directed.push_back('{mk(ppat_pkg::OP_POINT2D, 120, 215, -7, 0, 0, 0), 0, none});
		directed.push_back('{mk(ppat_pkg::OP_POINT3D, -32768, -32768, -32768, 1, 2, 3), 0,
			none});
		foreach (directed[i])
			send(directed[i].req, directed[i].typed, directed[i].want);
		drain();

		// extreme registers, with scaling forced on
		write_all(2, 63'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 2'd1);
		send(mk(ppat_pkg::OP_POINT3D, 32767, 32767, 32767, 0, 0, 0), 0, none);
		send(mk(ppat_pkg::OP_POINT3D, -32768, 1, -1, 0, 0, 0), 0, none);
		drain();
		write_all(3, 63'h0, 32'h7FFF_FFFF, 2'd3);
		send(mk(ppat_pkg::OP_POINT2D, -32768, 32767, 0, 0, 0, 0), 0, none);
		send(mk(ppat_pkg::OP_SPACE2D, 0, 0, 0, 3, 4, 0), 0, none);
		drain();

		// random phases through every idle pattern and several register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_pct = 0; stall_pct = 0; end
				1: begin send_pct = 66; stall_pct = 0; end
				2: begin send_pct = 0; stall_pct = 66; end
				default: begin send_pct = 26; stall_pct = 26; end
			endcase
			write_all(ph == 7 ? 3 : ph % 3,
				ph == 6 ? 63'h7FFF_FFFF_FFFF_FFFF : 63'({$urandom, $urandom}),
				ph == 5 ? 32'h8000_0000 :
					32'(ph % 2 ? $urandom_range(131072) : $urandom),
				2'(ph % 4));
			for (int n = 0; n < 160; n++) begin
				op = $urandom_range(9);
				r = mk(op < 3 ? ppat_pkg::OP_POINT3D : op < 6 ? ppat_pkg::OP_POINT2D :
					op < 8 ? ppat_pkg::OP_SPACE3D : ppat_pkg::OP_SPACE2D,
					0, 0, 0, 0, 0, 0);
				r.first_x = rand_coord(); r.first_y = rand_coord();
				r.first_z = rand_coord(); r.second_x = rand_coord();
				r.second_y = rand_coord(); r.second_z = rand_coord();
				send(r, 0, none);
			end
			drain();
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (mismatches == 0)
			$display("[plot_point_affine_transform] OK");
		else
			$display("[plot_point_affine_transform] ERROR");
		$finish;
	end
endmodule
